@@ sv/mel_pkg.sv @@
// ----------------------------------------------------------------------------
// mel_pkg
// Token kinds, function ids and the token record shared by the lexer blocks.
// ----------------------------------------------------------------------------
package mel_pkg;

    localparam logic [3:0] K_ADD   = 4'd0;
    localparam logic [3:0] K_SUB   = 4'd1;
    localparam logic [3:0] K_MUL   = 4'd2;
    localparam logic [3:0] K_DIV   = 4'd3;
    localparam logic [3:0] K_POW   = 4'd4;
    localparam logic [3:0] K_LP    = 4'd5;
    localparam logic [3:0] K_RP    = 4'd6;
    localparam logic [3:0] K_VAR   = 4'd7;
    localparam logic [3:0] K_FUNC  = 4'd8;
    localparam logic [3:0] K_CONST = 4'd9;
    localparam logic [3:0] K_NUM   = 4'd10;
    localparam logic [3:0] K_EMPTY = 4'd11;
    localparam logic [3:0] K_END   = 4'd12;

    localparam logic [2:0] F_NONE  = 3'd0;
    localparam logic [2:0] F_COS   = 3'd0;
    localparam logic [2:0] F_COT   = 3'd1;
    localparam logic [2:0] F_EXP   = 3'd2;
    localparam logic [2:0] F_SIN   = 3'd3;
    localparam logic [2:0] F_LOG   = 3'd4;
    localparam logic [2:0] F_LOG10 = 3'd5;
    localparam logic [2:0] F_TAN   = 3'd6;
    localparam logic [2:0] F_TG    = 3'd7;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  fid;
        logic [15:0] start;
        logic [6:0]  len;
        logic        last;
    } t_token;

    // Tokens produced by one byte, zero to two of them.
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

endpackage

@@ sv/mel_core.sv @@
// ----------------------------------------------------------------------------
// mel_core
// Scanner state and the single-pass decode of one byte into up to two tokens.
// ----------------------------------------------------------------------------
module mel_core #(
    parameter int NUM_MAX_LEN = 32,
    parameter int POS_BITS    = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [7:0]     i_ch,
    output mel_pkg::t_push o_push
);
    import mel_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_C     = 5'd1;
    localparam logic [4:0] S_CO    = 5'd2;
    localparam logic [4:0] S_E     = 5'd3;
    localparam logic [4:0] S_EX    = 5'd4;
    localparam logic [4:0] S_P     = 5'd5;
    localparam logic [4:0] S_S     = 5'd6;
    localparam logic [4:0] S_SI    = 5'd7;
    localparam logic [4:0] S_L     = 5'd8;
    localparam logic [4:0] S_LO    = 5'd9;
    localparam logic [4:0] S_LOG   = 5'd10;
    localparam logic [4:0] S_LOG1  = 5'd11;
    localparam logic [4:0] S_T     = 5'd12;
    localparam logic [4:0] S_TA    = 5'd13;
    localparam logic [4:0] S_NINT  = 5'd14;
    localparam logic [4:0] S_NFRAC = 5'd15;
    localparam logic [4:0] S_NEXP  = 5'd16;
    localparam logic [4:0] S_NEXPD = 5'd17;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [6:0] NUM_CAP  = 7'(NUM_MAX_LEN);

    function automatic t_token mk_tok(input logic [3:0] kind, input logic [2:0] fid,
                                      input logic [POS_BITS-1:0] start,
                                      input logic [6:0] len);
        t_token     t;
        logic [31:0] w;
        w       = 32'(start);
        t.kind  = kind;
        t.fid   = fid;
        t.start = w[15:0];
        t.len   = len;
        t.last  = 1'b0;
        return t;
    endfunction

    logic [4:0]          r_state, n_state;
    logic [6:0]          r_nlen, n_nlen;
    logic [POS_BITS-1:0] r_start, n_start;
    logic [POS_BITS-1:0] r_bpos, n_bpos;

    logic                is_dig;
    logic [POS_BITS-1:0] p;

    // decode of the byte as it would be seen from the idle state
    logic                id_emit, id_open, id_digit, id_end;
    logic [4:0]          id_state;
    t_token              id_tok;

    logic                do_idle, do_fail, do_num;
    logic [4:0]          num_next;
    logic [6:0]          nl;
    logic [1:0]          cnt;
    t_token              tk [2];

    assign is_dig = (i_ch >= CH_0) && (i_ch <= CH_9);
    assign p      = r_bpos;
    assign nl     = r_nlen + 7'd1;

    always_comb begin
        id_emit  = 1'b0;
        id_open  = 1'b0;
        id_digit = 1'b0;
        id_end   = 1'b0;
        id_state = S_IDLE;
        id_tok   = mk_tok(K_EMPTY, F_NONE, p, 7'd0);
        case (i_ch)
            CH_SPACE, CH_TAB: begin
            end
            CH_ADD: begin id_emit = 1'b1; id_tok = mk_tok(K_ADD, F_NONE, p, 7'd1); end
            CH_SUB: begin id_emit = 1'b1; id_tok = mk_tok(K_SUB, F_NONE, p, 7'd1); end
            CH_MUL: begin id_emit = 1'b1; id_tok = mk_tok(K_MUL, F_NONE, p, 7'd1); end
            CH_DIV: begin id_emit = 1'b1; id_tok = mk_tok(K_DIV, F_NONE, p, 7'd1); end
            CH_POW: begin id_emit = 1'b1; id_tok = mk_tok(K_POW, F_NONE, p, 7'd1); end
            CH_LP:  begin id_emit = 1'b1; id_tok = mk_tok(K_LP, F_NONE, p, 7'd1); end
            CH_RP:  begin id_emit = 1'b1; id_tok = mk_tok(K_RP, F_NONE, p, 7'd1); end
            CH_X:   begin id_emit = 1'b1; id_tok = mk_tok(K_VAR, F_NONE, p, 7'd1); end
            CH_C:   begin id_open = 1'b1; id_state = S_C; end
            CH_E:   begin id_open = 1'b1; id_state = S_E; end
            CH_P:   begin id_open = 1'b1; id_state = S_P; end
            CH_S:   begin id_open = 1'b1; id_state = S_S; end
            CH_L:   begin id_open = 1'b1; id_state = S_L; end
            CH_T:   begin id_open = 1'b1; id_state = S_T; end
            CH_NUL: begin
                id_emit = 1'b1;
                id_end  = 1'b1;
                id_tok  = mk_tok(K_END, F_NONE, p, 7'd0);
            end
            default: begin
                if (is_dig) begin
                    id_digit = 1'b1;
                end else begin
                    id_emit = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_nlen   = r_nlen;
        n_start  = r_start;
        n_bpos   = r_bpos + POS_BITS'(1);
        do_idle  = 1'b0;
        do_fail  = 1'b0;
        do_num   = 1'b0;
        num_next = S_IDLE;
        cnt      = 2'd0;
        tk[0]    = '0;
        tk[1]    = '0;

        case (r_state)
            S_C:  if (i_ch == CH_O) n_state = S_CO; else do_fail = 1'b1;
            S_CO: begin
                if (i_ch == CH_S) begin
                    tk[cnt[0]] = mk_tok(K_FUNC, F_COS, r_start, 7'd3); cnt = cnt + 2'd1;
                    n_state = S_IDLE;
                end else if (i_ch == CH_T) begin
                    tk[cnt[0]] = mk_tok(K_FUNC, F_COT, r_start, 7'd3); cnt = cnt + 2'd1;
                    n_state = S_IDLE;
                end else begin
                    do_fail = 1'b1;
                end
            end
            S_E:  if (i_ch == CH_X) n_state = S_EX; else do_fail = 1'b1;
            S_EX: begin
                if (i_ch == CH_P) begin
                    tk[cnt[0]] = mk_tok(K_FUNC, F_EXP, r_start, 7'd3); cnt = cnt + 2'd1;
                    n_state = S_IDLE;
                end else begin
                    do_fail = 1'b1;
                end
            end
            S_P: begin
                if (i_ch == CH_I) begin
                    tk[cnt[0]] = mk_tok(K_CONST, F_NONE, r_start, 7'd2); cnt = cnt + 2'd1;
                    n_state = S_IDLE;
                end else begin
                    do_fail = 1'b1;
                end
            end
            S_S:  if (i_ch == CH_I) n_state = S_SI; else do_fail = 1'b1;
            S_SI: begin
                if (i_ch == CH_N) begin
                    tk[cnt[0]] = mk_tok(K_FUNC, F_SIN, r_start, 7'd3); cnt = cnt + 2'd1;
                    n_state = S_IDLE;
                end else begin
                    do_fail = 1'b1;
                end
            end
            S_L:  if (i_ch == CH_O) n_state = S_LO; else do_fail = 1'b1;
            S_LO: if (i_ch == CH_G) n_state = S_LOG; else do_fail = 1'b1;
            S_LOG: begin
                // anything but '1' closes log and is lexed on its own
                if (i_ch == CH_1) begin
                    n_state = S_LOG1;
                end else begin
                    tk[cnt[0]] = mk_tok(K_FUNC, F_LOG, r_start, 7'd3); cnt = cnt + 2'd1;
                    do_idle = 1'b1;
                end
            end
            S_LOG1: begin
                if (i_ch == CH_0) begin
                    tk[cnt[0]] = mk_tok(K_FUNC, F_LOG10, r_start, 7'd5); cnt = cnt + 2'd1;
                    n_state = S_IDLE;
                end else begin
                    do_fail = 1'b1;
                end
            end
            S_T: begin
                if (i_ch == CH_A) begin
                    n_state = S_TA;
                end else if (i_ch == CH_G) begin
                    tk[cnt[0]] = mk_tok(K_FUNC, F_TG, r_start, 7'd2); cnt = cnt + 2'd1;
                    n_state = S_IDLE;
                end else begin
                    do_fail = 1'b1;
                end
            end
            S_TA: begin
                if (i_ch == CH_N) begin
                    tk[cnt[0]] = mk_tok(K_FUNC, F_TAN, r_start, 7'd3); cnt = cnt + 2'd1;
                    n_state = S_IDLE;
                end else begin
                    do_fail = 1'b1;
                end
            end
            S_NINT: begin
                if (is_dig) begin
                    do_num = 1'b1; num_next = S_NINT;
                end else if (i_ch == CH_DOT) begin
                    do_num = 1'b1; num_next = S_NFRAC;
                end else if (i_ch == CH_E || i_ch == CH_UE) begin
                    do_num = 1'b1; num_next = S_NEXP;
                end else begin
                    do_idle = 1'b1;
                end
            end
            S_NFRAC: begin
                if (is_dig) begin
                    do_num = 1'b1; num_next = S_NFRAC;
                end else if (i_ch == CH_E || i_ch == CH_UE) begin
                    do_num = 1'b1; num_next = S_NEXP;
                end else begin
                    do_idle = 1'b1;
                end
            end
            S_NEXP: begin
                if (is_dig || i_ch == CH_ADD || i_ch == CH_SUB) begin
                    do_num = 1'b1; num_next = S_NEXPD;
                end else begin
                    do_idle = 1'b1;
                end
            end
            S_NEXPD: begin
                if (is_dig) begin
                    do_num = 1'b1; num_next = S_NEXPD;
                end else begin
                    do_idle = 1'b1;
                end
            end
            default: do_idle = 1'b1;
        endcase

        // a byte that leaves a number emits the number first
        if (do_idle && (r_state == S_NINT || r_state == S_NFRAC ||
                        r_state == S_NEXP || r_state == S_NEXPD)) begin
            tk[cnt[0]] = mk_tok(K_NUM, F_NONE, r_start, r_nlen); cnt = cnt + 2'd1;
            n_nlen = 7'd0;
        end

        if (do_num) begin
            if (nl >= NUM_CAP) begin
                tk[cnt[0]] = mk_tok(K_NUM, F_NONE, r_start, nl); cnt = cnt + 2'd1;
                n_state = S_IDLE;
                n_nlen  = 7'd0;
            end else begin
                n_state = num_next;
                n_nlen  = nl;
            end
        end

        if (do_fail) begin
            tk[cnt[0]] = mk_tok(K_EMPTY, F_NONE, r_start, 7'd0); cnt = cnt + 2'd1;
            n_state = S_IDLE;
            if (i_ch == CH_NUL) begin
                tk[cnt[0]] = mk_tok(K_END, F_NONE, p, 7'd0); cnt = cnt + 2'd1;
                n_bpos = '0;
            end
        end

        if (do_idle) begin
            n_state = id_state;
            if (id_emit) begin
                tk[cnt[0]] = id_tok; cnt = cnt + 2'd1;
            end
            if (id_open) n_start = p;
            if (id_digit) begin
                n_start = p;
                n_nlen  = 7'd1;
                n_state = S_NINT;
            end
            if (id_end) n_bpos = '0;
        end

        // flag the final token of this byte
        if (cnt == 2'd1) tk[0].last = 1'b1;
        if (cnt == 2'd2) tk[1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nlen  <= 7'd0;
            r_start <= '0;
            r_bpos  <= '0;
        end else if (i_en) begin
            r_state <= n_state;
            r_nlen  <= n_nlen;
            r_start <= n_start;
            r_bpos  <= n_bpos;
        end
    end

    assign o_push.cnt  = i_en ? cnt : 2'd0;
    assign o_push.tok0 = tk[0];
    assign o_push.tok1 = tk[1];

endmodule

@@ sv/mel_fifo.sv @@
// ----------------------------------------------------------------------------
// mel_fifo
// Four-entry token queue: takes up to two tokens a cycle, delivers one per pop.
// ----------------------------------------------------------------------------
module mel_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mel_pkg::t_push  i_push,
    input  logic            i_pop,
    output mel_pkg::t_token o_tok,
    output logic            o_valid,
    output logic            o_room2
);
    import mel_pkg::*;

    t_token     r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr] <= i_push.tok0;
        if (i_push.cnt == 2'd2) r_mem[r_wr + 2'd1] <= i_push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wr    <= r_wr + i_push.cnt;
            r_rd    <= r_rd + {1'b0, i_pop};
            r_count <= r_count + {1'b0, i_push.cnt} - {2'b00, i_pop};
        end
    end

    assign o_tok   = r_mem[r_rd];
    assign o_valid = (r_count != 3'd0);
    assign o_room2 = (r_count <= 3'd2);

endmodule

@@ sv/math_expression_lexer.sv @@
// ----------------------------------------------------------------------------
// math_expression_lexer
// Streaming tokenizer for arithmetic expressions, one text byte per beat.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the input register until the queue has room
//   for two tokens; its tokens are then written into the queue and offered.
// Throughput: one byte per cycle while each byte yields at most one token and
//   i_stall is low; the output port delivers one token per cycle, so two-token
//   bytes are paced by the four-entry token queue.
// Reset: synchronous, active low; scanner returns to idle, positions to zero.
// ----------------------------------------------------------------------------
module math_expression_lexer #(
    parameter int NUM_MAX_LEN = 32,
    parameter int POS_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [2:0]  o_function_id,
    output logic [15:0] o_token_start,
    output logic [6:0]  o_token_length,
    output logic        o_last
);
    import mel_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       room2, core_en, accept, pop;
    t_push      push;
    t_token     tok;

    assign core_en = r_in_valid && room2;
    assign o_stall = r_in_valid && !room2;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (core_en) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_in_ch <= i_ch;
    end

    mel_core #(
        .NUM_MAX_LEN (NUM_MAX_LEN),
        .POS_BITS    (POS_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (core_en),
        .i_ch    (r_in_ch),
        .o_push  (push)
    );

    assign pop = o_valid && !i_stall;

    mel_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_tok   (tok),
        .o_valid (o_valid),
        .o_room2 (room2)
    );

    assign o_token_kind   = tok.kind;
    assign o_function_id  = tok.fid;
    assign o_token_start  = tok.start;
    assign o_token_length = tok.len;
    assign o_last         = tok.last;

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt == 2'd2 |-> (push.tok1.last && !push.tok0.last))
        else $error("two-token beat with wrong last flags");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_kind == K_END) |-> o_last)
        else $error("end token without last");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt != 2'd0 |-> room2)
        else $error("token push without queue room");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_in_valid)
        else $error("accepted byte lost from input register");

endmodule
